/* design/rhb_pkg.sv */
`default_nettype none

package rhb_pkg;

  // field widths of the channels and the configuration port
  localparam int SAMPLE_W   = 32;
  localparam int BINS_W     = 9;
  localparam int IDX_W      = 8;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // divider sizing: numerator is offset times bin count, quotient is below 2**BINS_W
  localparam int NUM_W     = SAMPLE_W + BINS_W;
  localparam int DIV_CNT_W = $clog2(BINS_W + 1);

  // parameter defaults
  localparam int DEF_MAX_BINS    = 256;
  localparam int DEF_COUNT_WIDTH = 32;

  // register reset values
  localparam logic signed [SAMPLE_W-1:0] RST_MIN_VALUE = 32'sd0;
  localparam logic signed [SAMPLE_W-1:0] RST_MAX_VALUE = 32'sd65536;
  localparam logic [BINS_W-1:0]          RST_BINS      = 9'd256;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 2'd2;

  // command codes
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // placement codes of a result
  typedef enum logic [1:0] {
    PLACE_BIN   = 2'd0,
    PLACE_BELOW = 2'd1,
    PLACE_ABOVE = 2'd2,
    PLACE_NONE  = 2'd3
  } place_t;

  // divider request and response
  typedef struct packed {
    logic                start;
    logic [NUM_W-1:0]    numer;
    logic [SAMPLE_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [BINS_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/rhb_if.sv */
`default_nettype none

// command channel
interface rhb_in_if import rhb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [SAMPLE_W-1:0] sample;
  logic [IDX_W-1:0]    read_index;

  modport source (output valid, output command, output sample, output read_index,
                  input ready);
  modport sink   (input valid, input command, input sample, input read_index,
                  output ready);
endinterface

// result channel
interface rhb_out_if import rhb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           placement;
  logic [IDX_W-1:0]     bin_index;
  logic [OUT_CNT_W-1:0] bin_count;
  logic [OUT_CNT_W-1:0] below_count;
  logic [OUT_CNT_W-1:0] above_count;
  logic [OUT_CNT_W-1:0] max_bin_count;

  modport source (output valid, output placement, output bin_index, output bin_count,
                  output below_count, output above_count, output max_bin_count,
                  input ready);
  modport sink   (input valid, input placement, input bin_index, input bin_count,
                  input below_count, input above_count, input max_bin_count,
                  output ready);
endinterface

`default_nettype wire

/* design/range_histogram_binner.sv */
`default_nettype none

// Fixed-range histogram over signed Q16.16 samples. Bin counts live in one
// single-port RAM of MAX_BINS words; below, above and peak counters are flops.
// An in-range sample passes from accept to the next accept through these
// steps: range-check, form offset times bin count, the bit-serial divider
// that produces the bin number, read the bin, write it back, load the output
// register once it is free and, back in idle, take the next beat. A sample
// outside the range goes from range check to the output register, a bin read
// through one RAM read. A clear command sweeps the bin RAM one word a cycle;
// the same sweep runs after reset, and no beat is accepted during it
// (configuration writes are always taken). The result register lets the next
// beat be accepted while a result waits to be taken.
// Counts saturate at COUNT_WIDTH bits; the outputs show their low 32 bits.
module range_histogram_binner import rhb_pkg::*; #(
  parameter int MAX_BINS    = DEF_MAX_BINS,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rhb_in_if.sink                     in_ch,
  rhb_out_if.source                  out_ch,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int EXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_RMW,
    S_RDOUT,
    S_OUT
  } state_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] low_word(input cnt_t c);
    logic [EXT_W-1:0] e;
    e = EXT_W'(c);
    return e[OUT_CNT_W-1:0];
  endfunction

  // configuration registers
  logic signed [SAMPLE_W-1:0] cfg_min_r;
  logic signed [SAMPLE_W-1:0] cfg_max_r;
  logic [BINS_W-1:0]          cfg_bins_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r  <= RST_MIN_VALUE;
      cfg_max_r  <= RST_MAX_VALUE;
      cfg_bins_r <= RST_BINS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_VALUE:   cfg_min_r  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_MAX_VALUE:   cfg_max_r  <= cfg_wdata[SAMPLE_W-1:0];
        CFG_BINS_IN_USE: cfg_bins_r <= cfg_wdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective bin count and range edges
  logic [BINS_W-1:0]          nb;
  logic signed [SAMPLE_W-1:0] lo;
  logic signed [SAMPLE_W-1:0] hi;

  always_comb begin
    if (cfg_bins_r == '0) begin
      nb = BINS_W'(1);
    end else if (32'(cfg_bins_r) > 32'(MAX_BINS)) begin
      nb = BINS_W'(MAX_BINS);
    end else begin
      nb = cfg_bins_r;
    end
  end

  assign lo = cfg_min_r;
  assign hi = (cfg_max_r < cfg_min_r) ? cfg_min_r : cfg_max_r;

  // control and working registers
  state_t                     state_r, state_nxt;
  cmd_t                       cmd_r, cmd_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic [IDX_W-1:0]           rdidx_r, rdidx_nxt;
  logic [SAMPLE_W-1:0]        diff_r, diff_nxt;
  logic [SAMPLE_W-1:0]        range_r, range_nxt;
  logic [BIN_W-1:0]           bin_r, bin_nxt;
  logic                       hit_r, hit_nxt;
  logic [BIN_W-1:0]           clr_addr_r, clr_addr_nxt;
  logic                       clr_reply_r, clr_reply_nxt;
  cnt_t                       below_r, below_nxt;
  cnt_t                       above_r, above_nxt;
  cnt_t                       peak_r, peak_nxt;
  place_t                     res_place_r, res_place_nxt;
  logic [IDX_W-1:0]           res_idx_r, res_idx_nxt;
  cnt_t                       res_count_r, res_count_nxt;
  logic                       out_valid_r, out_valid_nxt;
  place_t                     out_place_r, out_place_nxt;
  logic [IDX_W-1:0]           out_idx_r, out_idx_nxt;
  cnt_t                       out_count_r, out_count_nxt;
  cnt_t                       out_below_r, out_below_nxt;
  cnt_t                       out_above_r, out_above_nxt;
  cnt_t                       out_peak_r, out_peak_nxt;

  // bin RAM port and divider
  logic             ram_en;
  logic             ram_we;
  logic [BIN_W-1:0] ram_addr;
  cnt_t             ram_wdata;
  cnt_t             ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic signed [SAMPLE_W:0] diff_w;
  logic signed [SAMPLE_W:0] range_w;
  logic [BINS_W-1:0]        quot_clamp;
  cnt_t                     bump;
  logic                     out_free;

  assign diff_w  = {sample_r[SAMPLE_W-1], sample_r} - {lo[SAMPLE_W-1], lo};
  assign range_w = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};

  // offset times bin count feeds the divider's remainder register
  assign div_req.start = (state_r == S_MUL);
  assign div_req.numer = diff_r * nb;
  assign div_req.denom = range_r;

  // bin number: zero range maps to bin 0, top edge clamps to the last bin
  always_comb begin
    if (range_r == '0) begin
      quot_clamp = '0;
    end else if (div_rsp.quot >= nb) begin
      quot_clamp = nb - BINS_W'(1);
    end else begin
      quot_clamp = div_rsp.quot;
    end
  end

  assign bump     = sat_inc(ram_rdata);
  assign out_free = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    sample_nxt    = sample_r;
    rdidx_nxt     = rdidx_r;
    diff_nxt      = diff_r;
    range_nxt     = range_r;
    bin_nxt       = bin_r;
    hit_nxt       = hit_r;
    clr_addr_nxt  = clr_addr_r;
    clr_reply_nxt = clr_reply_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    peak_nxt      = peak_r;
    res_place_nxt = res_place_r;
    res_idx_nxt   = res_idx_r;
    res_count_nxt = res_count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_place_nxt = out_place_r;
    out_idx_nxt   = out_idx_r;
    out_count_nxt = out_count_r;
    out_below_nxt = out_below_r;
    out_above_nxt = out_above_r;
    out_peak_nxt  = out_peak_r;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = bin_r;
    ram_wdata     = bump;
    in_ch.ready   = 1'b0;

    case (state_r)
      // zero the bin RAM one word a cycle
      S_CLEAR: begin
        ram_en       = 1'b1;
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + BIN_W'(1);
        if (clr_addr_r == BIN_W'(MAX_BINS - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = clr_reply_r ? S_OUT : S_IDLE;
        end
      end

      // take a beat
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt    = cmd_t'(in_ch.command);
          sample_nxt = in_ch.sample;
          rdidx_nxt  = in_ch.read_index;
          state_nxt  = S_EVAL;
        end
      end

      // decode the command, range-check a sample
      S_EVAL: begin
        res_place_nxt = PLACE_NONE;
        res_idx_nxt   = '0;
        res_count_nxt = '0;
        case (cmd_r)
          CMD_ADD: begin
            if (sample_r < lo) begin
              below_nxt     = sat_inc(below_r);
              res_place_nxt = PLACE_BELOW;
              state_nxt     = S_OUT;
            end else if (sample_r > hi) begin
              above_nxt     = sat_inc(above_r);
              res_place_nxt = PLACE_ABOVE;
              state_nxt     = S_OUT;
            end else begin
              diff_nxt  = diff_w[SAMPLE_W-1:0];
              range_nxt = range_w[SAMPLE_W-1:0];
              state_nxt = S_MUL;
            end
          end
          CMD_CLEAR: begin
            below_nxt     = '0;
            above_nxt     = '0;
            peak_nxt      = '0;
            clr_addr_nxt  = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end
          CMD_READ: begin
            res_idx_nxt = rdidx_r;
            hit_nxt     = ({1'b0, rdidx_r} < nb);
            ram_en      = ({1'b0, rdidx_r} < nb);
            ram_addr    = BIN_W'(rdidx_r);
            state_nxt   = S_RDOUT;
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end

      // divider is loaded this cycle
      S_MUL: begin
        state_nxt = S_DIV;
      end

      // wait for the quotient, then fetch the bin
      S_DIV: begin
        if (div_rsp.done) begin
          ram_en      = 1'b1;
          ram_addr    = BIN_W'(quot_clamp);
          bin_nxt     = BIN_W'(quot_clamp);
          res_idx_nxt = quot_clamp[IDX_W-1:0];
          state_nxt   = S_RMW;
        end
      end

      // bump the bin and track the peak
      S_RMW: begin
        ram_en        = 1'b1;
        ram_we        = 1'b1;
        res_place_nxt = PLACE_BIN;
        res_count_nxt = bump;
        if (bump > peak_r) begin
          peak_nxt = bump;
        end
        state_nxt = S_OUT;
      end

      // bin read data
      S_RDOUT: begin
        res_count_nxt = hit_r ? ram_rdata : '0;
        state_nxt     = S_OUT;
      end

      // load the result register once it is free
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_place_nxt = res_place_r;
          out_idx_nxt   = res_idx_r;
          out_count_nxt = res_count_r;
          out_below_nxt = below_r;
          out_above_nxt = above_r;
          out_peak_nxt  = peak_r;
          clr_reply_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      clr_reply_r <= 1'b0;
      below_r     <= '0;
      above_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_reply_r <= clr_reply_nxt;
      below_r     <= below_nxt;
      above_r     <= above_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    sample_r    <= sample_nxt;
    rdidx_r     <= rdidx_nxt;
    diff_r      <= diff_nxt;
    range_r     <= range_nxt;
    bin_r       <= bin_nxt;
    hit_r       <= hit_nxt;
    res_place_r <= res_place_nxt;
    res_idx_r   <= res_idx_nxt;
    res_count_r <= res_count_nxt;
    out_place_r <= out_place_nxt;
    out_idx_r   <= out_idx_nxt;
    out_count_r <= out_count_nxt;
    out_below_r <= out_below_nxt;
    out_above_r <= out_above_nxt;
    out_peak_r  <= out_peak_nxt;
  end

  // bin count storage
  rhb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_BINS)
  ) u_bins (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // bin number divider
  rhb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // result beat
  assign out_ch.valid         = out_valid_r;
  assign out_ch.placement     = out_place_r;
  assign out_ch.bin_index     = out_idx_r;
  assign out_ch.bin_count     = low_word(out_count_r);
  assign out_ch.below_count   = low_word(out_below_r);
  assign out_ch.above_count   = low_word(out_above_r);
  assign out_ch.max_bin_count = low_word(out_peak_r);

endmodule

`default_nettype wire

/* design/rhb_ram.sv */
`default_nettype none

module rhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read-first, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* design/rhb_div.sv */
`default_nettype none

module rhb_div import rhb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [NUM_W-1:0]     rem_r;
  logic [NUM_W-2:0]     dvs_r;
  logic [BINS_W-1:0]    quot_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [NUM_W-1:0] dvs_ext;
  logic             take;

  // restoring step: one quotient bit per cycle
  assign dvs_ext = {1'b0, dvs_r};
  assign take    = (rem_r >= dvs_ext);

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(BINS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.numer;
      dvs_r  <= {req.denom, {(BINS_W-1){1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - dvs_ext;
      end
      quot_r <= {quot_r[BINS_W-2:0], take};
      dvs_r  <= dvs_r >> 1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

`default_nettype wire

/* tb/sv/tb_range_histogram_binner.sv */
`default_nettype none

module tb_range_histogram_binner;
  import rhb_pkg::*;

  localparam logic [1:0]           CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int                   NBINS        = DEF_MAX_BINS;
  localparam int                   RANDOM_BEATS = 925;
  localparam int                   CYCLE_LIMIT  = 600000;
  localparam int                   TAIL_CYCLES  = 40;
  localparam int                   PRINT_CAP    = 100;
  localparam longint               S32_MIN      = -(longint'(1) << 31);
  localparam longint               S32_MAX      = (longint'(1) << 31) - 1;

  typedef struct packed {
    place_t               placement;
    logic [IDX_W-1:0]     bin_index;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [OUT_CNT_W-1:0] below_count;
    logic [OUT_CNT_W-1:0] above_count;
    logic [OUT_CNT_W-1:0] max_bin_count;
  } hist_result_t;

  // mirror of the histogram state, predicts each result and checks it
  class hist_mirror;
    logic signed [SAMPLE_W-1:0] min_q;
    logic signed [SAMPLE_W-1:0] max_q;
    logic [BINS_W-1:0]          bins_q;
    logic [OUT_CNT_W-1:0]       tally [NBINS];
    logic [OUT_CNT_W-1:0]       below_q;
    logic [OUT_CNT_W-1:0]       above_q;
    logic [OUT_CNT_W-1:0]       peak_q;
    hist_result_t               awaited [$];
    int errors;
    int checked;
    int n_binned, n_below, n_above, n_reads, n_clears, n_unused;

    function new();
      min_q   = RST_MIN_VALUE;
      max_q   = RST_MAX_VALUE;
      bins_q  = RST_BINS;
      errors  = 0;
      checked = 0;
      n_binned = 0; n_below = 0; n_above = 0;
      n_reads  = 0; n_clears = 0; n_unused = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (tally[i]) tally[i] = '0;
      below_q = '0;
      above_q = '0;
      peak_q  = '0;
    endfunction

    function int unsigned live_bins();
      if (bins_q == 0) return 1;
      if (bins_q > NBINS) return NBINS;
      return bins_q;
    endfunction

    function longint low_edge();
      return longint'(min_q);
    endfunction

    // the maximum is pulled up to the minimum when it lies below it
    function longint high_edge();
      return (max_q < min_q) ? longint'(min_q) : longint'(max_q);
    endfunction

    function logic [OUT_CNT_W-1:0] bump(logic [OUT_CNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_MIN_VALUE:   min_q = d;
        CFG_MAX_VALUE:   max_q = d;
        CFG_BINS_IN_USE: bins_q = d[BINS_W-1:0];
        default: ;
      endcase
    endfunction

    // accepted command beat: update state, queue the result it must produce
    function void take_beat(logic [1:0] cmd, logic [SAMPLE_W-1:0] smp,
                            logic [IDX_W-1:0] ridx);
      hist_result_t r;
      longint       v, lo, hi, span, slot;
      int unsigned  nb;
      r = '0;
      r.placement = PLACE_NONE;
      lo = low_edge();
      hi = high_edge();
      nb = live_bins();
      v  = longint'($signed(smp));
      case (cmd)
        CMD_ADD: begin
          if (v < lo) begin
            below_q = bump(below_q);
            r.placement = PLACE_BELOW;
            n_below++;
          end else if (v > hi) begin
            above_q = bump(above_q);
            r.placement = PLACE_ABOVE;
            n_above++;
          end else begin
            span = hi - lo;
            slot = 0;
            if (span != 0) slot = ((v - lo) * longint'(nb)) / span;
            if (slot >= nb) slot = nb - 1;
            tally[slot] = bump(tally[slot]);
            if (tally[slot] > peak_q) peak_q = tally[slot];
            r.placement = PLACE_BIN;
            r.bin_index = IDX_W'(slot);
            r.bin_count = tally[slot];
            n_binned++;
          end
        end
        CMD_CLEAR: begin
          wipe();
          n_clears++;
        end
        CMD_READ: begin
          r.bin_index = ridx;
          if (ridx < nb) r.bin_count = tally[ridx];
          n_reads++;
        end
        default: n_unused++;
      endcase
      r.below_count   = below_q;
      r.above_count   = above_q;
      r.max_bin_count = peak_q;
      awaited.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("mismatch at result %0d, %s: got 0x%0h, want 0x%0h",
                 checked, what, got, want);
    endtask

    task match_result(hist_result_t got);
      hist_result_t want;
      if (awaited.size() == 0) begin
        report("result beat with nothing awaited", got.bin_count, 0);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.placement !== want.placement)
        report("placement", got.placement, want.placement);
      if (got.bin_index !== want.bin_index)
        report("bin_index", got.bin_index, want.bin_index);
      if (got.bin_count !== want.bin_count)
        report("bin_count", got.bin_count, want.bin_count);
      if (got.below_count !== want.below_count)
        report("below_count", got.below_count, want.below_count);
      if (got.above_count !== want.above_count)
        report("above_count", got.above_count, want.above_count);
      if (got.max_bin_count !== want.max_bin_count)
        report("max_bin_count", got.max_bin_count, want.max_bin_count);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rhb_in_if  in_ch ();
  rhb_out_if out_ch ();

  hist_mirror hm;
  int         cycle_cnt = 0;
  int         tx_mode   = 0;
  int         rx_mode   = 0;
  int         settings  = 1;

  range_histogram_binner i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycle_cnt, hm.awaited.size());
      $display("tb_range_histogram_binner NOT OK");
      $finish;
    end
  end

  // observe register writes and beats on both channels
  always @(posedge clk) begin
    hist_result_t seen;
    if (rst_n) begin
      if (cfg_wr_en) hm.note_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready)
        hm.take_beat(in_ch.command, in_ch.sample, in_ch.read_index);
      if (out_ch.valid && out_ch.ready) begin
        seen.placement     = place_t'(out_ch.placement);
        seen.bin_index     = out_ch.bin_index;
        seen.bin_count     = out_ch.bin_count;
        seen.below_count   = out_ch.below_count;
        seen.above_count   = out_ch.above_count;
        seen.max_bin_count = out_ch.max_bin_count;
        hm.match_result(seen);
      end
    end
  end

  // idle length for one beat: none, uniform, or occasional
  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 15);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // result side: random stalls before taking each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap(rx_mode);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // one command beat, called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic [1:0] cmd, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] ridx);
    int g;
    g = draw_gap(tx_mode);
    if (g != 0) begin
      in_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.command    = cmd;
    in_ch.sample     = smp;
    in_ch.read_index = ridx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // hold the sender until every awaited result has been taken
  task automatic drain();
    in_ch.valid = 1'b0;
    while (hm.awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(negedge clk);
  endtask

  // new register setting on an idle block; spare bits of the bins word are noise
  task automatic set_regs(input logic [31:0] lo, input logic [31:0] hi,
                          input logic [BINS_W-1:0] nb, input bit spare);
    drain();
    put_reg(CFG_MIN_VALUE, lo);
    put_reg(CFG_MAX_VALUE, hi);
    put_reg(CFG_BINS_IN_USE, ($urandom() << BINS_W) | 32'(nb));
    if (spare || $urandom_range(0, 2) == 0) put_reg(CFG_SPARE, $urandom());
    cfg_wr_en = 1'b0;
    settings++;
    tx_mode = $urandom_range(0, 2);
    rx_mode = $urandom_range(0, 2);
  endtask

  task automatic random_setting();
    int                kind;
    logic [31:0]       lo, hi;
    logic [BINS_W-1:0] nb;
    kind = $urandom_range(0, 5);
    lo   = $urandom();
    hi   = $urandom();
    nb   = BINS_W'($urandom_range(1, 256));
    case (kind)
      // narrow range, few bins: counts pile up
      0: begin
        lo = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
        hi = lo + 32'($urandom_range(1, 1 << 18));
        nb = BINS_W'($urandom_range(1, 16));
      end
      // full signed span
      2: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
        if ($urandom_range(0, 1) == 0) nb = NBINS;
      end
      // zero range
      3: hi = lo;
      // bins word of zero or beyond the bin store
      4: begin
        lo = 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
        hi = lo + 32'($urandom_range(1, 1 << 17));
        nb = ($urandom_range(0, 1) == 0) ? '0 : BINS_W'($urandom_range(NBINS + 1, 511));
      end
      // maximum below the minimum
      5: begin
        lo = 32'($urandom_range(0, 1 << 20));
        hi = lo - 32'($urandom_range(1, 1 << 20));
      end
      default: ;
    endcase
    set_regs(lo, hi, nb, 1'b0);
  endtask

  // sample aimed at the current range: inside, on edges, outside, or anywhere
  function automatic logic [31:0] pick_sample();
    longint      lo, hi, span, rnd, v, e;
    int unsigned nb;
    int          way;
    lo   = hm.low_edge();
    hi   = hm.high_edge();
    span = hi - lo;
    nb   = hm.live_bins();
    rnd  = {$urandom() >> 1, $urandom()};
    way  = $urandom_range(0, 99);
    if (way < 12 && lo > S32_MIN) begin
      v = lo - 1 - rnd % (lo - S32_MIN);
    end else if (way < 24 && hi < S32_MAX) begin
      v = hi + 1 + rnd % (S32_MAX - hi);
    end else if (way < 38) begin
      e = $urandom_range(0, nb);
      e = (e * span + nb - 1) / nb;
      v = lo + e;
      if (e > 0 && $urandom_range(0, 1) == 1) v = v - 1;
    end else if (way < 42) begin
      return $urandom();
    end else begin
      v = lo + rnd % (span + 1);
    end
    return v[31:0];
  endfunction

  task automatic run_phase(input int beats);
    int                   pick;
    logic [1:0]           cmd;
    logic [SAMPLE_W-1:0]  smp;
    logic [IDX_W-1:0]     ridx;
    for (int k = 0; k < beats; k++) begin
      pick = $urandom_range(0, 99);
      smp  = $urandom();
      ridx = IDX_W'($urandom());
      if (pick < 72) begin
        cmd = CMD_ADD;
        smp = pick_sample();
      end else if (pick < 92) begin
        cmd = CMD_READ;
        if ($urandom_range(0, 4) != 0)
          ridx = IDX_W'($urandom_range(0, hm.live_bins() - 1));
      end else if (pick < 95) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = CMD_UNUSED;
      end
      if ($urandom_range(0, 199) == 0) drain();
      send_beat(cmd, smp, ridx);
    end
  endtask

  // main sequence
  initial begin
    int sent;
    int beats;
    hm               = new();
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = CFG_MIN_VALUE;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_ADD;
    in_ch.sample     = '0;
    in_ch.read_index = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting: range 0 to 1.0 over all bins
    tx_mode = 2;
    rx_mode = 2;
    send_beat(CMD_ADD, 32'h0000_0000, 8'hFF);
    send_beat(CMD_ADD, 32'h0001_0000, 8'h00);
    send_beat(CMD_ADD, 32'h0000_8000, 8'h5A);
    send_beat(CMD_ADD, 32'hFFFF_FFFF, 8'hA5);
    send_beat(CMD_ADD, 32'h8000_0000, 8'h00);
    send_beat(CMD_ADD, 32'h0001_0001, 8'h00);
    send_beat(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
    send_beat(CMD_READ, 32'hFFFF_FFFF, 8'h00);
    send_beat(CMD_READ, 32'h0000_0000, 8'hFF);
    send_beat(CMD_UNUSED, 32'h1234_5678, 8'h80);
    send_beat(CMD_CLEAR, 32'h0000_0000, 8'h00);
    send_beat(CMD_READ, 32'h0000_0000, 8'h80);

    // full signed span with a bins word of zero
    set_regs(32'h8000_0000, 32'h7FFF_FFFF, '0, 1'b1);
    send_beat(CMD_ADD, 32'h8000_0000, 8'h00);
    send_beat(CMD_ADD, 32'h7FFF_FFFF, 8'h00);
    send_beat(CMD_READ, 32'h0000_0000, 8'h01);
    send_beat(CMD_READ, 32'h0000_0000, 8'hFF);

    // maximum below minimum collapses the range; bins beyond the store
    set_regs(32'd100, 32'hFFFF_FFFB, 9'h1FF, 1'b0);
    send_beat(CMD_ADD, 32'd100, 8'h00);
    send_beat(CMD_ADD, 32'd99, 8'h00);
    send_beat(CMD_ADD, 32'd101, 8'h00);

    // three bins over -1.0 to 1.0, counts kept from before
    set_regs(32'hFFFF_0000, 32'h0001_0000, 9'd3, 1'b0);
    send_beat(CMD_ADD, 32'h0000_0000, 8'h00);
    send_beat(CMD_ADD, 32'h0001_0000, 8'h00);
    send_beat(CMD_ADD, 32'hFFFF_0000, 8'h00);
    send_beat(CMD_READ, 32'h0000_0000, 8'd2);
    send_beat(CMD_READ, 32'h0000_0000, 8'd3);
    send_beat(CMD_READ, 32'h0000_0000, 8'd200);

    // random phases, each under its own setting
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      beats = $urandom_range(30, 110);
      if (beats > RANDOM_BEATS - sent) beats = RANDOM_BEATS - sent;
      random_setting();
      run_phase(beats);
      sent += beats;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d binned, %0d below, %0d above, %0d reads, %0d clears, %0d unused",
             hm.n_binned, hm.n_below, hm.n_above, hm.n_reads, hm.n_clears, hm.n_unused);
    $display("over %0d register settings: %0d results compared, %0d mismatches",
             settings, hm.checked, hm.errors);
    if (hm.errors == 0) begin
      $display("tb_range_histogram_binner OK");
    end else begin
      $display("tb_range_histogram_binner NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* range_histogram_binner.f */
design/rhb_pkg.sv
design/rhb_if.sv
design/rhb_ram.sv
design/rhb_div.sv
design/range_histogram_binner.sv
tb/sv/tb_range_histogram_binner.sv
